/* hw/rtl/tank_level_rollup_with_drop_alarm_macros.svh */
// Assertion macros for the tank level roll-up block.
// Used by the controller and the top level; depends on nothing.
`ifndef TANK_LEVEL_ROLLUP_WITH_DROP_ALARM_MACROS_SVH
`define TANK_LEVEL_ROLLUP_WITH_DROP_ALARM_MACROS_SVH

// Property that must hold on every clock edge outside reset
`define TLR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the next cycle
`define TLR_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* hw/rtl/tlr_pkg.sv */
// Shared types and constants for the tank level roll-up block.
// No dependencies.
package tlr_pkg;

    localparam int NUM_TANKS = 8;
    localparam int TANK_W = 3;

    // Result kinds
    localparam logic [2:0] KIND_ALARM   = 3'd0;
    localparam logic [2:0] KIND_SAMPLE  = 3'd1;
    localparam logic [2:0] KIND_MEDIUM  = 3'd2;
    localparam logic [2:0] KIND_LONG    = 3'd3;
    localparam logic [2:0] KIND_ONLINE  = 3'd4;
    localparam logic [2:0] KIND_OFFLINE = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_THR1   = 3'd0;
    localparam logic [2:0] CFG_THR2   = 3'd1;
    localparam logic [2:0] CFG_THR3   = 3'd2;
    localparam logic [2:0] CFG_MEDIUM = 3'd3;
    localparam logic [2:0] CFG_LONG   = 3'd4;
    localparam logic [2:0] CFG_LIVE   = 3'd5;

    // Datapath operations requested by the controller
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;  // latch input, read tank
    localparam logic [3:0] OP_DIV_MNOW  = 4'd2;  // now / medium period
    localparam logic [3:0] OP_DIV_MST   = 4'd3;  // medium_start / medium period
    localparam logic [3:0] OP_DIV_LNOW  = 4'd4;
    localparam logic [3:0] OP_DIV_LST   = 4'd5;
    localparam logic [3:0] OP_DIV_MAVG  = 4'd6;  // medium average
    localparam logic [3:0] OP_DIV_LAVG  = 4'd7;  // long average
    localparam logic [3:0] OP_WRITE     = 4'd8;  // commit tank state
    localparam logic [3:0] OP_TICK_TANK = 4'd9;  // check one tank on a tick

    typedef struct packed {
        logic [3:0]        op;
        logic [TANK_W-1:0] tick_idx;
    } tlr_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic in_range;
        logic is_tick;
        logic has_prev;       // last_time nonzero
        logic alarm0;
        logic was_active;
        logic med_same;       // bucket compare valid after both divides
        logic med_has;        // medium_count nonzero
        logic alarm1;
        logic long_same;
        logic long_has;
        logic alarm2;
        logic tick_off;       // tank tick_idx goes offline
    } tlr_stat_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  tank;
        logic [1:0]  stage;
        logic [31:0] rtime;
        logic [15:0] level;
        logic [15:0] count;
    } tlr_res_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

/* hw/rtl/tank_level_rollup_with_drop_alarm.sv */
// Top level of the tank level roll-up with drop alarm.
// Depends on tlr_pkg, tlr_ctrl, tlr_datapath and the assertion macro header.
//
// One item at a time: the input stalls from acceptance until the item is
// finished. A sample runs six divides on the shared 32-bit radix-2 divider
// (two per period to compare buckets, two averages), each awaited in S_WAIT
// before the next step, then emits its results as the output stall allows.
// A tick checks each tank in turn (S_TICK, S_TCHK), with S_TOUT for each
// tank that goes offline, and ends in S_TEND. Up to eight results per item.
`include "tank_level_rollup_with_drop_alarm_macros.svh"
module tank_level_rollup_with_drop_alarm
    import tlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [2:0]  tank_index,
    input  logic [15:0] level_sample,
    input  logic [31:0] now_s,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [2:0]  tank_number,
    output logic [1:0]  alarm_stage,
    output logic [31:0] record_time,
    output logic [15:0] level_value,
    output logic [15:0] sample_count,
    output logic        last
);

    tlr_cmd_t  cmd;
    tlr_stat_t stat;
    tlr_res_t  r0, r1, r2, r3, r4, r5, r6, r7, ores;

    tlr_datapath u_dp (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .action, .tank_index, .level_sample, .now_s,
        .cmd, .stat,
        .res_alarm0 (r0), .res_sample (r1), .res_online (r2), .res_alarm1 (r3),
        .res_medium (r4), .res_alarm2 (r5), .res_long (r6), .res_offline (r7)
    );

    tlr_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .cmd, .stat,
        .res_alarm0 (r0), .res_sample (r1), .res_online (r2), .res_alarm1 (r3),
        .res_medium (r4), .res_alarm2 (r5), .res_long (r6), .res_offline (r7),
        .out_valid, .out_stall, .out_res (ores), .out_last (last)
    );

    assign event_kind   = ores.kind;
    assign tank_number  = ores.tank;
    assign alarm_stage  = ores.stage;
    assign record_time  = ores.rtime;
    assign level_value  = ores.level;
    assign sample_count = ores.count;

    `TLR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ores), "held")
    `TLR_ASSERT(a_kind_ok, !out_valid || event_kind <= KIND_OFFLINE, "bad event kind")
    `TLR_ASSERT_NEXT(a_stall_busy, in_valid && !in_stall, in_stall, "second item taken")

endmodule

/* hw/rtl/tlr_div.sv */
// Radix-2 restoring divider, 32 by 32 bits, one quotient bit per cycle.
// Depends on tlr_pkg.
module tlr_div
    import tlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient
);

    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [33:0] trial;

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        trial    = {1'b0, rem_reg, quo_reg[31]} - {2'b00, dvs_reg};
        if (start)
        begin
            cnt_next = 6'd32;
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[33])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[30:0], quo_reg[31]};
                quo_next = {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = quo_reg;

endmodule

/* hw/rtl/tlr_datapath.sv */
// Datapath: configuration, per-tank state, divider and result staging.
// Depends on tlr_pkg and tlr_div.
module tlr_datapath
    import tlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        action,
    input  logic [2:0]  tank_index,
    input  logic [15:0] level_sample,
    input  logic [31:0] now_s,
    input  tlr_cmd_t    cmd,
    output tlr_stat_t   stat,
    output tlr_res_t    res_alarm0,
    output tlr_res_t    res_sample,
    output tlr_res_t    res_online,
    output tlr_res_t    res_alarm1,
    output tlr_res_t    res_medium,
    output tlr_res_t    res_alarm2,
    output tlr_res_t    res_long,
    output tlr_res_t    res_offline
);

    logic [15:0] thr1_reg, thr2_reg, thr3_reg;
    logic [31:0] med_per_reg, long_per_reg, live_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr1_reg     <= 16'd50;
            thr2_reg     <= 16'd50;
            thr3_reg     <= 16'd50;
            med_per_reg  <= 32'd3600;
            long_per_reg <= 32'd86400;
            live_reg     <= 32'd60;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THR1:   thr1_reg     <= cfg_data[15:0];
                CFG_THR2:   thr2_reg     <= cfg_data[15:0];
                CFG_THR3:   thr3_reg     <= cfg_data[15:0];
                CFG_MEDIUM: med_per_reg  <= cfg_data;
                CFG_LONG:   long_per_reg <= cfg_data;
                CFG_LIVE:   live_reg     <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Per-tank state, all cleared by reset
    logic [NUM_TANKS-1:0] act_reg;
    logic [31:0] ltime_reg [NUM_TANKS];
    logic [15:0] llev_reg  [NUM_TANKS];
    logic [15:0] p1_reg    [NUM_TANKS];
    logic [15:0] p2_reg    [NUM_TANKS];
    logic [15:0] p3_reg    [NUM_TANKS];
    logic [31:0] mst_reg   [NUM_TANKS];
    logic [31:0] msum_reg  [NUM_TANKS];
    logic [15:0] mcnt_reg  [NUM_TANKS];
    logic [31:0] lst_reg   [NUM_TANKS];
    logic [31:0] lsum_reg  [NUM_TANKS];
    logic [15:0] lcnt_reg  [NUM_TANKS];

    // Latched input item
    logic        tick_reg;
    logic [2:0]  t_reg;
    logic [15:0] lvl_reg;
    logic [31:0] now_reg;
    logic [31:0] q_reg;     // quotient captured for bucket compare
    logic [15:0] mavg_reg, lavg_reg;
    logic        med_same_reg, long_same_reg;
    logic        offline_reg;

    // Divider
    logic        div_start, div_busy;
    logic [31:0] div_a, div_b, div_q;
    logic [31:0] mper, lper;
    logic        pend_reg;
    logic [3:0]  pend_op_reg;

    assign mper = (med_per_reg == 32'd0) ? 32'd1 : med_per_reg;
    assign lper = (long_per_reg == 32'd0) ? 32'd1 : long_per_reg;

    always_comb
    begin
        div_start = 1'b0;
        div_a     = now_reg;
        div_b     = mper;
        unique case (cmd.op)
            OP_DIV_MNOW: begin div_start = 1'b1; div_a = now_reg;          div_b = mper; end
            OP_DIV_MST:  begin div_start = 1'b1; div_a = mst_reg[t_reg];   div_b = mper; end
            OP_DIV_LNOW: begin div_start = 1'b1; div_a = now_reg;          div_b = lper; end
            OP_DIV_LST:  begin div_start = 1'b1; div_a = lst_reg[t_reg];   div_b = lper; end
            OP_DIV_MAVG:
            begin
                div_start = 1'b1;
                div_a     = msum_reg[t_reg];
                div_b     = {16'd0, mcnt_reg[t_reg]};
            end
            OP_DIV_LAVG:
            begin
                div_start = 1'b1;
                div_a     = lsum_reg[t_reg];
                div_b     = {16'd0, lcnt_reg[t_reg]};
            end
            default: ;
        endcase
    end

    tlr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Capture quotients when the divider finishes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= 1'b0;
            pend_op_reg <= OP_NONE;
        end
        else if (div_start)
        begin
            pend_reg    <= 1'b1;
            pend_op_reg <= cmd.op;
        end
        else if (pend_reg && !div_busy)
        begin
            pend_reg <= 1'b0;
        end
    end

    logic [15:0] q_sat;
    assign q_sat = (div_q[31:16] != 16'd0) ? 16'hFFFF : div_q[15:0];

    always_ff @(posedge clk)
    begin
        if (pend_reg && !div_busy && !div_start)
        begin
            unique case (pend_op_reg)
                OP_DIV_MNOW, OP_DIV_LNOW: q_reg <= div_q;
                OP_DIV_MST:  med_same_reg  <= (div_q == q_reg);
                OP_DIV_LST:  long_same_reg <= (div_q == q_reg);
                OP_DIV_MAVG: mavg_reg <= q_sat;
                OP_DIV_LAVG: lavg_reg <= q_sat;
                default: ;
            endcase
        end
        if (cmd.op == OP_LOAD)
        begin
            tick_reg <= action;
            t_reg    <= tank_index;
            lvl_reg  <= level_sample;
            now_reg  <= now_s;
        end
        if (cmd.op == OP_TICK_TANK)
            offline_reg <= act_reg[cmd.tick_idx]
                && ((now_reg - ltime_reg[cmd.tick_idx]) >= live_reg);
    end

    // Drop tests
    logic [16:0] d1, d2, d3;
    logic        a0, a1, a2;
    assign d1 = {1'b0, p1_reg[t_reg]} - {1'b0, lvl_reg};
    assign d2 = {1'b0, p2_reg[t_reg]} - {1'b0, lvl_reg};
    assign d3 = {1'b0, p3_reg[t_reg]} - {1'b0, lvl_reg};
    assign a0 = (p1_reg[t_reg] > lvl_reg) && (d1[15:0] >= thr1_reg);
    assign a1 = (p2_reg[t_reg] > lvl_reg) && (d2[15:0] >= thr2_reg);
    assign a2 = (p3_reg[t_reg] > lvl_reg) && (d3[15:0] >= thr3_reg);

    // Status to the controller
    always_comb
    begin
        stat.div_busy   = div_busy || pend_reg;
        stat.in_range   = ({1'b0, t_reg} < 4'(NUM_TANKS));
        stat.is_tick    = tick_reg;
        stat.has_prev   = (ltime_reg[t_reg] != 32'd0);
        stat.alarm0     = a0;
        stat.was_active = act_reg[t_reg];
        stat.med_same   = med_same_reg;
        stat.med_has    = (mcnt_reg[t_reg] != 16'd0);
        stat.alarm1     = a1;
        stat.long_same  = long_same_reg;
        stat.long_has   = (lcnt_reg[t_reg] != 16'd0);
        stat.alarm2     = a2;
        stat.tick_off   = offline_reg;
    end

    // Candidate results
    always_comb
    begin
        res_alarm0  = '{KIND_ALARM, t_reg, 2'd0, now_reg, d1[15:0], 16'd0};
        res_sample  = '{KIND_SAMPLE, t_reg, 2'd0, ltime_reg[t_reg], llev_reg[t_reg], 16'd1};
        res_online  = '{KIND_ONLINE, t_reg, 2'd0, now_reg, 16'd0, 16'd0};
        res_alarm1  = '{KIND_ALARM, t_reg, 2'd1, now_reg, d2[15:0], 16'd0};
        res_medium  = '{KIND_MEDIUM, t_reg, 2'd0, mst_reg[t_reg], mavg_reg, mcnt_reg[t_reg]};
        res_alarm2  = '{KIND_ALARM, t_reg, 2'd2, now_reg, d3[15:0], 16'd0};
        res_long    = '{KIND_LONG, t_reg, 2'd0, lst_reg[t_reg], lavg_reg, lcnt_reg[t_reg]};
        res_offline = '{KIND_OFFLINE, cmd.tick_idx, 2'd0, now_reg, 16'd0, 16'd0};
    end

    // Commit of tank state; a tick clears the active bit of a tank that goes offline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
            for (int i = 0; i < NUM_TANKS; i++)
            begin
                ltime_reg[i] <= '0; llev_reg[i] <= '0;
                p1_reg[i] <= '0; p2_reg[i] <= '0; p3_reg[i] <= '0;
                mst_reg[i] <= '0; msum_reg[i] <= '0; mcnt_reg[i] <= '0;
                lst_reg[i] <= '0; lsum_reg[i] <= '0; lcnt_reg[i] <= '0;
            end
        end
        else if (cmd.op == OP_TICK_TANK)
        begin
            if (act_reg[cmd.tick_idx]
                && ((now_reg - ltime_reg[cmd.tick_idx]) >= live_reg))
                act_reg[cmd.tick_idx] <= 1'b0;
        end
        else if (cmd.op == OP_WRITE)
        begin
            act_reg[t_reg]   <= 1'b1;
            p1_reg[t_reg]    <= lvl_reg;
            ltime_reg[t_reg] <= now_reg;
            llev_reg[t_reg]  <= lvl_reg;
            if (med_same_reg)
            begin
                msum_reg[t_reg] <= sat_add32(msum_reg[t_reg], {16'd0, lvl_reg});
                mcnt_reg[t_reg] <= sat_add16(mcnt_reg[t_reg], 16'd1);
            end
            else
            begin
                p2_reg[t_reg]   <= lvl_reg;
                mst_reg[t_reg]  <= now_reg;
                msum_reg[t_reg] <= {16'd0, lvl_reg};
                mcnt_reg[t_reg] <= 16'd1;
                if (long_same_reg)
                begin
                    lsum_reg[t_reg] <= sat_add32(lsum_reg[t_reg], msum_reg[t_reg]);
                    lcnt_reg[t_reg] <= sat_add16(lcnt_reg[t_reg], mcnt_reg[t_reg]);
                end
                else
                begin
                    p3_reg[t_reg]   <= lvl_reg;
                    lst_reg[t_reg]  <= now_reg;
                    lsum_reg[t_reg] <= msum_reg[t_reg];
                    lcnt_reg[t_reg] <= mcnt_reg[t_reg];
                end
            end
        end
    end

endmodule

/* hw/rtl/tlr_ctrl.sv */
// Controller: runs a sample through divides, results and commit, or a tick scan.
// Depends on tlr_pkg and the assertion macro header.
`include "tank_level_rollup_with_drop_alarm_macros.svh"
module tlr_ctrl
    import tlr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output tlr_cmd_t  cmd,
    input  tlr_stat_t stat,
    input  tlr_res_t  res_alarm0,
    input  tlr_res_t  res_sample,
    input  tlr_res_t  res_online,
    input  tlr_res_t  res_alarm1,
    input  tlr_res_t  res_medium,
    input  tlr_res_t  res_alarm2,
    input  tlr_res_t  res_long,
    input  tlr_res_t  res_offline,
    output logic      out_valid,
    input  logic      out_stall,
    output tlr_res_t  out_res,
    output logic      out_last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_MNOW  = 4'd2;
    localparam logic [3:0] S_MST   = 4'd3;
    localparam logic [3:0] S_LNOW  = 4'd4;
    localparam logic [3:0] S_LST   = 4'd5;
    localparam logic [3:0] S_MAVG  = 4'd6;
    localparam logic [3:0] S_LAVG  = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;
    localparam logic [3:0] S_TICK  = 4'd10;
    localparam logic [3:0] S_TCHK  = 4'd11;
    localparam logic [3:0] S_TOUT  = 4'd12;
    localparam logic [3:0] S_TEND  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [3:0] after_reg, after_next;      // state after a divide wait
    logic [2:0] ti_reg, ti_next;            // tick scan index
    logic [7:0] list_reg, list_next;        // pending sample results
    logic       toff_reg, toff_next;        // an offline queued
    tlr_res_t   qres_reg, qres_next;        // the queued offline
    logic       ov_reg, ov_next;
    tlr_res_t   ores_reg, ores_next;
    logic       olast_reg, olast_next;

    // Plan of sample results in model order
    logic [7:0] plan;
    logic       al0, al1;
    always_comb
    begin
        al0 = stat.has_prev && stat.alarm0;
        al1 = !stat.med_same && stat.med_has && !al0 && stat.alarm1;
        plan[0] = al0;
        plan[1] = stat.has_prev;
        plan[2] = !stat.was_active;
        plan[3] = al1;
        plan[4] = !stat.med_same && stat.med_has;
        plan[5] = !stat.med_same && !stat.long_same && stat.long_has
                  && !al0 && !al1 && stat.alarm2;
        plan[6] = !stat.med_same && !stat.long_same && stat.long_has;
        plan[7] = 1'b0;
    end

    // Lowest pending result
    logic [2:0] pick;
    tlr_res_t   pick_res;
    logic [7:0] rest;
    always_comb
    begin
        pick = 3'd0;
        for (int i = 6; i >= 0; i--)
            if (list_reg[i])
                pick = 3'(i);
        rest = list_reg & ~(8'd1 << pick);
        unique case (pick)
            3'd0: pick_res = res_alarm0;
            3'd1: pick_res = res_sample;
            3'd2: pick_res = res_online;
            3'd3: pick_res = res_alarm1;
            3'd4: pick_res = res_medium;
            3'd5: pick_res = res_alarm2;
            3'd6: pick_res = res_long;
            default: pick_res = res_long;
        endcase
    end

    logic out_free;
    assign out_free = !ov_reg || !out_stall;

    // Next-state logic
    always_comb
    begin
        state_next  = state_reg;
        after_next  = after_reg;
        ti_next     = ti_reg;
        list_next   = list_reg;
        toff_next   = toff_reg;
        qres_next   = qres_reg;
        ov_next     = ov_reg && out_stall;
        ores_next   = ores_reg;
        olast_next  = olast_reg;
        cmd.op      = OP_NONE;
        cmd.tick_idx = ti_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.is_tick)
                begin
                    ti_next    = '0;
                    toff_next  = 1'b0;
                    state_next = S_TICK;
                end
                else if (!stat.in_range)
                    state_next = S_IDLE;
                else
                begin
                    cmd.op     = OP_DIV_MNOW;
                    after_next = S_MST;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!stat.div_busy)
                    state_next = after_reg;
            end
            S_MST:  begin cmd.op = OP_DIV_MST;  after_next = S_LNOW; state_next = S_WAIT; end
            S_LNOW: begin cmd.op = OP_DIV_LNOW; after_next = S_LST;  state_next = S_WAIT; end
            S_LST:  begin cmd.op = OP_DIV_LST;  after_next = S_MAVG; state_next = S_WAIT; end
            S_MAVG: begin cmd.op = OP_DIV_MAVG; after_next = S_LAVG; state_next = S_WAIT; end
            S_LAVG:
            begin
                cmd.op     = OP_DIV_LAVG;
                after_next = S_MNOW;
                state_next = S_WAIT;
            end
            S_MNOW:
            begin
                // all quotients ready: plan results
                list_next  = plan;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (list_reg == 8'd0)
                begin
                    cmd.op     = OP_WRITE;
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    ores_next  = pick_res;
                    olast_next = (rest == 8'd0);
                    list_next  = rest;
                end
            end
            S_TICK:
            begin
                cmd.op     = OP_TICK_TANK;
                state_next = S_TCHK;
            end
            S_TCHK:
            begin
                if (stat.tick_off)
                    state_next = S_TOUT;
                else if (ti_reg == 3'(NUM_TANKS - 1))
                    state_next = S_TEND;
                else
                begin
                    ti_next    = ti_reg + 3'd1;
                    state_next = S_TICK;
                end
            end
            S_TOUT:
            begin
                // send the earlier offline, then queue this one
                if (!toff_reg || out_free)
                begin
                    if (toff_reg)
                    begin
                        ov_next    = 1'b1;
                        ores_next  = qres_reg;
                        olast_next = 1'b0;
                    end
                    qres_next  = res_offline;
                    toff_next  = 1'b1;
                    if (ti_reg == 3'(NUM_TANKS - 1))
                        state_next = S_TEND;
                    else
                    begin
                        ti_next    = ti_reg + 3'd1;
                        state_next = S_TICK;
                    end
                end
            end
            S_TEND:
            begin
                // the queued offline, if any, is the final result
                if (!toff_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    ov_next    = 1'b1;
                    ores_next  = qres_reg;
                    olast_next = 1'b1;
                    toff_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // A queued offline event waits in qres_reg until the next one or the scan end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            after_reg <= S_IDLE;
            ti_reg    <= '0;
            list_reg  <= '0;
            toff_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            ti_reg    <= ti_next;
            list_reg  <= list_next;
            toff_reg  <= toff_next;
            ov_reg    <= ov_next;
            olast_reg <= olast_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ores_reg <= ores_next;
        qres_reg <= qres_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;
    assign out_res   = ores_reg;
    assign out_last  = olast_reg;

    `TLR_ASSERT(a_tick_end, state_reg != S_TEND || ti_reg == 3'(NUM_TANKS - 1), "scan ended early")
    `TLR_ASSERT_NEXT(a_commit_idle, cmd.op == OP_WRITE, state_reg == S_IDLE, "commit not idle")
    `TLR_ASSERT(a_emit_list, state_reg != S_EMIT || list_reg[7] == 1'b0, "bad result list")

endmodule
